// ----- rtl/bdlr_pkg.sv -----
// Shared types, constants and the control store for the big-digit LCD renderer.
// No dependencies; every other file imports this package.
`default_nettype none

package bdlr_pkg;

  // Field widths of the request and result channels
  localparam int VALUE_W = 16;
  localparam int COL_W   = 6;
  localparam int ROW_W   = 2;
  localparam int CODE_W  = 8;
  localparam int CNT_W   = 3;   // digit counts and positions, 0..7

  // Parameter defaults
  localparam int MAX_DIGITS_DEF  = 4;
  localparam int DIGIT_PITCH_DEF = 4;

  localparam logic [CODE_W-1:0] SPACE_CODE = 8'd32;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_ORIGIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_ORIGIN    = 1'b1;

  // Elaboration-time power of ten
  function automatic int unsigned pow10(input int n);
    int unsigned p;
    p = 1;
    for (int i = 0; i < n; i++) begin
      p = p * 10;
    end
    return p;
  endfunction

  // Glyph cells: {defined, code[2:0]}; a cleared top bit leaves the cell blank.
  // Cells 0..2 are the upper row, 3..5 the lower row, left to right.
  localparam logic [3:0] GLYPH_TAB [10][6] = '{
    '{4'h8, 4'h9, 4'hA, 4'hB, 4'hC, 4'hD},
    '{4'h9, 4'hA, 4'h0, 4'hC, 4'hF, 4'hC},
    '{4'hE, 4'hE, 4'hA, 4'hB, 4'hC, 4'hC},
    '{4'hE, 4'hE, 4'hA, 4'hC, 4'hC, 4'hD},
    '{4'hB, 4'hC, 4'hF, 4'h0, 4'h0, 4'hF},
    '{4'hB, 4'hE, 4'hE, 4'hC, 4'hC, 4'hD},
    '{4'h8, 4'hE, 4'hE, 4'hB, 4'hC, 4'hD},
    '{4'h9, 4'h9, 4'hA, 4'h0, 4'h0, 4'hF},
    '{4'h8, 4'hE, 4'hA, 4'hB, 4'hC, 4'hD},
    '{4'h8, 4'hE, 4'hA, 4'hC, 4'hC, 4'hF}
  };

  function automatic logic [3:0] glyph_cell(input logic [3:0] digit, input logic [2:0] slot);
    logic [3:0] res;
    res = 4'h0;
    if (digit <= 4'd9 && slot <= 3'd5) begin
      res = GLYPH_TAB[digit][slot];
    end
    return res;
  endfunction

  // Datapath action selected by a control word
  typedef enum logic [2:0] {
    ACT_LOAD,        // take a request, clamp it
    ACT_EXTRACT,     // peel decimal digits by repeated subtraction
    ACT_STALE_INIT,  // point at the first stale position
    ACT_STALE,       // blank stale positions
    ACT_DIGIT_INIT,  // point at the leftmost digit, record digit count
    ACT_DBLANK,      // blank the current digit's 6 cells
    ACT_GLYPH        // write the current digit's glyph cells
  } act_t;

  // Branch condition tested when a step completes
  typedef enum logic [1:0] {
    BR_NEVER,
    BR_NO_STALE,
    BR_MORE_DIGITS
  } br_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXTRACT,
    S_STALE_INIT,
    S_STALE,
    S_DIGIT_INIT,
    S_DBLANK,
    S_GLYPH
  } step_t;

  typedef struct packed {
    act_t  act;
    br_t   br;
    step_t jmp;   // target when the branch is taken
    step_t nxt;   // target otherwise
  } ctl_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic done;         // current step finishes this cycle
    logic no_stale;     // no position needs blanking
    logic more_digits;  // another digit follows
  } sts_t;

  // Control store
  function automatic ctl_t ucode(input step_t s);
    ctl_t w;
    case (s)
      S_IDLE:       w = '{ACT_LOAD,       BR_NEVER,       S_IDLE,       S_EXTRACT};
      S_EXTRACT:    w = '{ACT_EXTRACT,    BR_NEVER,       S_IDLE,       S_STALE_INIT};
      S_STALE_INIT: w = '{ACT_STALE_INIT, BR_NO_STALE,    S_DIGIT_INIT, S_STALE};
      S_STALE:      w = '{ACT_STALE,      BR_NEVER,       S_IDLE,       S_DIGIT_INIT};
      S_DIGIT_INIT: w = '{ACT_DIGIT_INIT, BR_NEVER,       S_IDLE,       S_DBLANK};
      S_DBLANK:     w = '{ACT_DBLANK,     BR_NEVER,       S_IDLE,       S_GLYPH};
      S_GLYPH:      w = '{ACT_GLYPH,      BR_MORE_DIGITS, S_DBLANK,     S_IDLE};
      default:      w = '{ACT_LOAD,       BR_NEVER,       S_IDLE,       S_EXTRACT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/bdlr_if.sv -----
// Valid/ready channel interfaces: value requests in, cell writes out.
// Depends on bdlr_pkg for field widths.
`default_nettype none

interface bdlr_in_if
  import bdlr_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] shown_value;

  modport source (output valid, output shown_value, input ready);
  modport sink (input valid, input shown_value, output ready);
endinterface

interface bdlr_out_if
  import bdlr_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  cell_column;
  logic [ROW_W-1:0]  cell_row;
  logic [CODE_W-1:0] char_code;
  logic              last_write;

  modport source (output valid, output cell_column, output cell_row, output char_code,
                  output last_write, input ready);
  modport sink (input valid, input cell_column, input cell_row, input char_code,
                input last_write, output ready);
endinterface

`default_nettype wire

// ----- rtl/bdlr_useq.sv -----
// Microcode sequencer: step counter over the control store in bdlr_pkg.
// Advances on the datapath's done flag, branching on a selected condition.
`default_nettype none

module bdlr_useq
  import bdlr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire sts_t sts,
  output ctl_t      ctl
);

  step_t step_r, step_nxt;
  logic  taken;

  // Decode current word and pick the next step
  always_comb begin
    ctl = ucode(step_r);
    case (ctl.br)
      BR_NEVER:       taken = 1'b0;
      BR_NO_STALE:    taken = sts.no_stale;
      BR_MORE_DIGITS: taken = sts.more_digits;
      default:        taken = 1'b0;
    endcase
    if (!sts.done) begin
      step_nxt = step_r;
    end else if (taken) begin
      step_nxt = ctl.jmp;
    end else begin
      step_nxt = ctl.nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/big_digit_lcd_renderer.sv -----
// Big-digit LCD renderer: one request -> a run of cell writes, one per cycle at most.
// Steps: take the request, extract the digits (repeated subtraction), a setup step, blank
// the cells of any stale position, a second setup step, then blank and draw each digit.
// A new value is taken only once the sequencer is back in idle at the end of the run;
// back-pressure on the output channel stalls the cell writes.
// Reset (synchronous, rst_n low): sequencer idle, no result pending, origins 0, count 1.
`default_nettype none

module big_digit_lcd_renderer
  import bdlr_pkg::*;
#(
  parameter int MAX_DIGITS  = MAX_DIGITS_DEF,
  parameter int DIGIT_PITCH = DIGIT_PITCH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  bdlr_in_if.sink                    in_ch,
  bdlr_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned LIMIT = pow10(MAX_DIGITS) - 1;
  localparam int VW = $clog2(LIMIT + 1);
  localparam int JW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  ctl_t ctl;
  sts_t sts;

  bdlr_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .ctl   (ctl)
  );

  // Powers of ten for digit extraction
  logic [VW-1:0] p10_tab [MAX_DIGITS];
  for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_p10
    assign p10_tab[g] = VW'(pow10(g));
  end

  // Registers
  logic [COL_W-1:0]  col_org_r;
  logic [ROW_W-1:0]  row_org_r;
  logic [VW-1:0]     val_r, val_nxt;
  logic [JW-1:0]     j_r, j_nxt;
  logic [3:0]        dig_r, dig_nxt;
  logic [3:0]        digits_r [MAX_DIGITS];
  logic [3:0]        digits_nxt [MAX_DIGITS];
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  prev_r, prev_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [2:0]        c_r, c_nxt;
  logic              ov_r, ov_nxt;
  logic [COL_W-1:0]  ocol_r, ocol_nxt;
  logic [ROW_W-1:0]  orow_r, orow_nxt;
  logic [CODE_W-1:0] ocode_r, ocode_nxt;
  logic              olast_r, olast_nxt;

  // Combinational helpers
  logic              go;
  logic              out_load;
  logic [31:0]       raw_ext;
  logic [31:0]       clamped;
  logic              ge;
  logic [CNT_W-1:0]  cnt_eff;
  logic [CNT_W-1:0]  bound;
  logic [CNT_W-1:0]  k_inc;
  logic [CNT_W-1:0]  di;
  logic [3:0]        cur_digit;
  logic [3:0]        gcell;
  logic              adv;
  logic              lower;
  logic [1:0]        cell_i;
  logic [COL_W-1:0]  pos_col;
  logic [COL_W-1:0]  cell_col;
  logic [ROW_W-1:0]  cell_rw;

  assign go      = !ov_r || out_ch.ready;
  assign cnt_eff = (cnt_r == '0) ? CNT_W'(1) : cnt_r;
  assign bound   = (32'(prev_r) > MAX_DIGITS) ? CNT_W'(MAX_DIGITS) : prev_r;
  assign k_inc   = k_r + CNT_W'(1);
  assign ge      = val_r >= p10_tab[j_r];

  // Request clamp to 0..LIMIT
  assign raw_ext = in_ch.shown_value[VALUE_W-1] ? 32'd0
                 : {{(32-VALUE_W+1){1'b0}}, in_ch.shown_value[VALUE_W-2:0]};
  assign clamped = (raw_ext > 32'(LIMIT)) ? 32'(LIMIT) : raw_ext;

  // Cell addressing and glyph lookup
  assign di        = cnt_eff - CNT_W'(1) - k_r;
  assign cur_digit = digits_r[di[JW-1:0]];
  assign gcell     = glyph_cell(cur_digit, c_r);
  assign lower     = c_r >= 3'd3;
  assign cell_i    = lower ? 2'(c_r - 3'd3) : c_r[1:0];
  assign pos_col   = col_org_r + COL_W'(32'(k_r) * DIGIT_PITCH);
  assign cell_col  = pos_col + COL_W'(cell_i);
  assign cell_rw   = row_org_r + ROW_W'(lower);

  assign in_ch.ready = (ctl.act == ACT_LOAD);

  // Datapath actions under the control word
  always_comb begin
    val_nxt    = val_r;
    j_nxt      = j_r;
    dig_nxt    = dig_r;
    digits_nxt = digits_r;
    cnt_nxt    = cnt_r;
    prev_nxt   = prev_r;
    k_nxt      = k_r;
    c_nxt      = c_r;
    ocol_nxt   = ocol_r;
    orow_nxt   = orow_r;
    ocode_nxt  = ocode_r;
    olast_nxt  = olast_r;
    out_load   = 1'b0;
    adv        = 1'b0;
    sts.done        = 1'b0;
    sts.no_stale    = cnt_eff >= bound;
    sts.more_digits = k_inc != cnt_eff;

    case (ctl.act)
      ACT_LOAD: begin
        if (in_ch.valid) begin
          val_nxt  = clamped[VW-1:0];
          j_nxt    = JW'(MAX_DIGITS - 1);
          dig_nxt  = 4'd0;
          cnt_nxt  = '0;
          sts.done = 1'b1;
        end
      end
      ACT_EXTRACT: begin
        if (ge) begin
          val_nxt = val_r - p10_tab[j_r];
          dig_nxt = dig_r + 4'd1;
        end else begin
          digits_nxt[j_r] = dig_r;
          // first nonzero digit from the top fixes the count
          if (cnt_r == '0 && dig_r != 4'd0) begin
            cnt_nxt = CNT_W'(j_r) + CNT_W'(1);
          end
          dig_nxt = 4'd0;
          if (j_r == '0) begin
            sts.done = 1'b1;
          end else begin
            j_nxt = j_r - JW'(1);
          end
        end
      end
      ACT_STALE_INIT: begin
        k_nxt    = cnt_eff;
        c_nxt    = 3'd0;
        sts.done = 1'b1;
      end
      ACT_STALE: begin
        if (go) begin
          out_load  = 1'b1;
          ocol_nxt  = cell_col;
          orow_nxt  = cell_rw;
          ocode_nxt = SPACE_CODE;
          olast_nxt = 1'b0;
          if (c_r == 3'd5) begin
            c_nxt    = 3'd0;
            k_nxt    = k_inc;
            sts.done = k_inc >= bound;
          end else begin
            c_nxt = c_r + 3'd1;
          end
        end
      end
      ACT_DIGIT_INIT: begin
        k_nxt    = '0;
        c_nxt    = 3'd0;
        prev_nxt = cnt_eff;
        sts.done = 1'b1;
      end
      ACT_DBLANK: begin
        if (go) begin
          out_load  = 1'b1;
          ocol_nxt  = cell_col;
          orow_nxt  = cell_rw;
          ocode_nxt = SPACE_CODE;
          olast_nxt = 1'b0;
          if (c_r == 3'd5) begin
            c_nxt    = 3'd0;
            sts.done = 1'b1;
          end else begin
            c_nxt = c_r + 3'd1;
          end
        end
      end
      ACT_GLYPH: begin
        // undefined cells keep the blank and are passed over without a write
        adv = go || !gcell[3];
        if (go && gcell[3]) begin
          out_load  = 1'b1;
          ocol_nxt  = cell_col;
          orow_nxt  = cell_rw;
          ocode_nxt = {{(CODE_W-3){1'b0}}, gcell[2:0]};
          olast_nxt = (c_r == 3'd5) && !sts.more_digits;
        end
        if (adv) begin
          if (c_r == 3'd5) begin
            c_nxt    = 3'd0;
            k_nxt    = k_inc;
            sts.done = 1'b1;
          end else begin
            c_nxt = c_r + 3'd1;
          end
        end
      end
      default: begin
      end
    endcase

    // Output register
    if (out_load) begin
      ov_nxt = 1'b1;
    end else if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  // Control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_org_r <= '0;
      row_org_r <= '0;
      prev_r    <= CNT_W'(1);
      cnt_r     <= '0;
      k_r       <= '0;
      c_r       <= 3'd0;
      j_r       <= '0;
      dig_r     <= 4'd0;
      ov_r      <= 1'b0;
    end else begin
      prev_r <= prev_nxt;
      cnt_r  <= cnt_nxt;
      k_r    <= k_nxt;
      c_r    <= c_nxt;
      j_r    <= j_nxt;
      dig_r  <= dig_nxt;
      ov_r   <= ov_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_COLUMN_ORIGIN: col_org_r <= cfg_wdata[COL_W-1:0];
          CFG_ROW_ORIGIN:    row_org_r <= cfg_wdata[ROW_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    val_r    <= val_nxt;
    digits_r <= digits_nxt;
    ocol_r   <= ocol_nxt;
    orow_r   <= orow_nxt;
    ocode_r  <= ocode_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.cell_column = ocol_r;
  assign out_ch.cell_row    = orow_r;
  assign out_ch.char_code   = ocode_r;
  assign out_ch.last_write  = olast_r;

  // Assertions
  a_prev_range: assert property (@(posedge clk) disable iff (!rst_n)
    prev_r != '0 && 32'(prev_r) <= MAX_DIGITS)
    else $error("digit count memory out of range");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && olast_nxt |=> in_ch.ready)
    else $error("final cell write did not return the sequencer to idle");

  a_digit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.act == ACT_DBLANK || ctl.act == ACT_GLYPH) |-> k_r < cnt_eff)
    else $error("digit position beyond the digit count");

endmodule

`default_nettype wire
